@@ hdl/osrb_pkg.sv @@
package osrb_pkg;

   // fixed field widths
   localparam int KEY_BITS = 7;
   localparam int MAX_KEY  = (2 ** KEY_BITS) - 1;

   // defaults for top level parameters
   localparam int DEPTH_DEFAULT      = 64;
   localparam int VALUE_BITS_DEFAULT = 56;

   // entries in the queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // stream length after reset
   localparam logic [KEY_BITS-1:0] STREAM_LENGTH_RESET = KEY_BITS'(64);

   // classification handed from front to back with each word
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic                out_of_range;
   } osrb_tag_type;

   // back end status seen by the top level
   typedef struct packed {
      logic                draining;
      logic [KEY_BITS:0]   next_expected;
   } osrb_stat_type;

endpackage

@@ hdl/osrb_if.sv @@
// input channel: keyed item
interface osrb_req_if import osrb_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [KEY_BITS-1:0]   item_key;
   logic [VALUE_BITS-1:0] item_value;

   modport source (output valid, output item_key, output item_value, input ready);
   modport sink   (input valid, input item_key, input item_value, output ready);
endinterface

// result channel
interface osrb_rsp_if import osrb_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  has_value;
   logic [KEY_BITS-1:0]   out_key;
   logic [VALUE_BITS-1:0] out_value;
   logic                  rejected;
   logic                  last_of_run;

   modport source (output valid, output has_value, output out_key, output out_value,
                   output rejected, output last_of_run, input ready);
   modport sink   (input valid, input has_value, input out_key, input out_value,
                   input rejected, input last_of_run, output ready);
endinterface

// configuration write channel: stream length
interface osrb_csr_if import osrb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] stream_length;

   modport source (output valid, output stream_length, input ready);
   modport sink   (input valid, input stream_length, output ready);
endinterface

@@ hdl/ordered_stream_reorder_buffer.sv @@
// Channel   Dir   Handshake        Word
// req_chan  in    valid / ready    item_key, item_value
// rsp_chan  out   valid / ready    has_value, out_key, out_value, rejected, last_of_run
// csr_chan  in    valid / ready    stream_length (always ready)
//
// A rejected or early word gives one marker from the back end.
// An expected word goes straight to the output register; each stored word drained
// after it takes a read and an emit, on the single slot memory read port.
// Reset needs no clearing pass: slot flags are flip-flops.
// A stalled rsp_chan holds the output register; a two word queue keeps
// req_chan open until it fills, and the back takes no word from it in a drain.
module ordered_stream_reorder_buffer import osrb_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   osrb_req_if.sink   req_chan,
   osrb_rsp_if.source rsp_chan,
   osrb_csr_if.sink   csr_chan
);

   localparam int SLOTS     = (DEPTH < MAX_KEY) ? DEPTH : MAX_KEY;
   localparam int TAG_BITS  = $bits(osrb_tag_type);
   localparam int WORD_BITS = TAG_BITS + VALUE_BITS;

   logic [KEY_BITS-1:0]   stream_length_ff;
   logic [KEY_BITS-1:0]   active_length;
   logic                  push_valid;
   logic                  push_ready;
   osrb_tag_type          push_tag;
   logic [VALUE_BITS-1:0] push_value;
   logic                  q_valid;
   logic                  q_pop;
   logic [WORD_BITS-1:0]  q_data;
   osrb_tag_type          q_tag;
   osrb_stat_type         stat;

   // stream length register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= STREAM_LENGTH_RESET;
      end else if (csr_chan.valid) begin
         stream_length_ff <= csr_chan.stream_length;
      end
   end

   // length in use is capped at the slot count
   assign active_length = (stream_length_ff > KEY_BITS'(SLOTS)) ? KEY_BITS'(SLOTS)
                                                               : stream_length_ff;

   osrb_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_chan      (req_chan),
      .active_length (active_length),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_tag      (push_tag),
      .push_value    (push_value)
   );

   osrb_queue #(
      .WIDTH (WORD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_tag, push_value}),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   assign q_tag = osrb_tag_type'(q_data[WORD_BITS-1:VALUE_BITS]);

   osrb_back #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .active_length (active_length),
      .q_valid       (q_valid),
      .q_tag         (q_tag),
      .q_value       (q_data[VALUE_BITS-1:0]),
      .q_pop         (q_pop),
      .stat          (stat),
      .rsp_chan      (rsp_chan)
   );

   // no new word is taken from the queue while a run drains
   assert property (@(posedge clock) disable iff (reset)
      stat.draining |-> !q_pop)
      else $error("queue popped during drain");

   // the expected key only moves forward
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (stat.next_expected >= $past(stat.next_expected)))
      else $error("next expected key moved back");

   // a word carrying a value is never flagged and has a real key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.has_value) |->
         (!rsp_chan.rejected && (rsp_chan.out_key != '0)))
      else $error("bad item result");

   // a drained item leaves the pointer past its key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.has_value) |->
         ({1'b0, rsp_chan.out_key} < stat.next_expected))
      else $error("emitted key not behind pointer");

endmodule

@@ hdl/osrb_front.sv @@
module osrb_front import osrb_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   osrb_req_if.sink              req_chan,
   input  logic [KEY_BITS-1:0]   active_length,
   output logic                  push_valid,
   input  logic                  push_ready,
   output osrb_tag_type          push_tag,
   output logic [VALUE_BITS-1:0] push_value
);

   // range check needs no state, so it is done here on the way in
   assign push_tag.key          = req_chan.item_key;
   assign push_tag.out_of_range = (req_chan.item_key == '0) ||
                                  (req_chan.item_key > active_length);

   assign push_value     = req_chan.item_value;
   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

@@ hdl/osrb_queue.sv @@
module osrb_queue import osrb_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != (PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop && pop_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/osrb_back.sv @@
module osrb_back import osrb_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KEY_BITS-1:0]   active_length,
   input  logic                  q_valid,
   input  osrb_tag_type          q_tag,
   input  logic [VALUE_BITS-1:0] q_value,
   output logic                  q_pop,
   output osrb_stat_type         stat,
   osrb_rsp_if.source            rsp_chan
);

   // keys never exceed MAX_KEY, so slots past that are never used
   localparam int SLOTS    = (DEPTH < MAX_KEY) ? DEPTH : MAX_KEY;
   localparam int IDX_BITS = $clog2(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [KEY_BITS:0]     next_ff, next_in;
   logic [SLOTS-1:0]      full_ff, full_in;
   logic [KEY_BITS-1:0]   rd_key_ff, rd_key_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  has_ff, has_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  rej_ff, rej_in;
   logic                  last_ff, last_in;

   // slot memory
   logic [VALUE_BITS-1:0] mem [SLOTS];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [IDX_BITS-1:0]   hit_idx;
   logic [IDX_BITS-1:0]   rd_idx;

   logic [KEY_BITS:0]     key_ext;
   logic [KEY_BITS:0]     len_ext;
   logic [KEY_BITS:0]     next_dec;
   logic                  out_free;
   logic                  load;
   logic                  reject;
   logic                  cont_hit;
   logic                  cont_next;

   assign key_ext  = {1'b0, q_tag.key};
   assign len_ext  = {1'b0, active_length};
   assign next_dec = next_ff - 1'b1;
   assign hit_idx  = IDX_BITS'(q_tag.key - 1'b1);
   assign rd_idx   = next_dec[IDX_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // out of range, duplicate or already passed keys drop with a rejected marker
   assign reject = q_tag.out_of_range || (key_ext < next_ff) || full_ff[hit_idx];

   // does the run go on after the hit key, and at the current pointer
   assign cont_hit  = ((key_ext + 1'b1) <= len_ext) && full_ff[IDX_BITS'(q_tag.key)];
   assign cont_next = (next_ff <= len_ext) && full_ff[rd_idx];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      next_in   = next_ff;
      full_in   = full_ff;
      rd_key_in = rd_key_ff;
      load      = 1'b0;
      has_in    = has_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      rej_in    = rej_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               load  = 1'b1;
               if (reject) begin
                  has_in   = 1'b0;
                  key_in   = '0;
                  value_in = '0;
                  rej_in   = 1'b1;
                  last_in  = 1'b1;
               end else if (key_ext != next_ff) begin
                  // early word: park it in its slot
                  mem_we           = 1'b1;
                  full_in[hit_idx] = 1'b1;
                  has_in           = 1'b0;
                  key_in           = '0;
                  value_in         = '0;
                  rej_in           = 1'b0;
                  last_in          = 1'b1;
               end else begin
                  // expected word goes straight out
                  has_in   = 1'b1;
                  key_in   = q_tag.key;
                  value_in = q_value;
                  rej_in   = 1'b0;
                  last_in  = !cont_hit;
                  next_in  = key_ext + 1'b1;
                  if (cont_hit) begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            mem_re          = 1'b1;
            full_in[rd_idx] = 1'b0;
            rd_key_in       = next_ff[KEY_BITS-1:0];
            next_in         = next_ff + 1'b1;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               has_in   = 1'b1;
               key_in   = rd_key_ff;
               value_in = rd_data_ff;
               rej_in   = 1'b0;
               last_in  = !cont_next;
               state_in = cont_next ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_ff      <= (KEY_BITS+1)'(1);
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_key_ff    <= rd_key_in;
         if (load) begin
            has_ff   <= has_in;
            key_ff   <= key_in;
            value_ff <= value_in;
            rej_ff   <= rej_in;
            last_ff  <= last_in;
         end
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[hit_idx] <= q_value;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.has_value   = has_ff;
   assign rsp_chan.out_key     = key_ff;
   assign rsp_chan.out_value   = value_ff;
   assign rsp_chan.rejected    = rej_ff;
   assign rsp_chan.last_of_run = last_ff;

   assign stat.draining      = (state_ff != ST_IDLE);
   assign stat.next_expected = next_ff;

endmodule
